// File: src/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared widths, codes and heap layout constants of the first-fit allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffa_pkg;

   // Heap geometry
   localparam int HEAP_WORDS = 65536;
   localparam int HEAP_AW    = $clog2(HEAP_WORDS);
   localparam int WORD_W     = 64;
   localparam int HEAP_BYTES = HEAP_WORDS * 8;

   // Payload widths
   localparam int REQ_W  = 20;
   localparam int ADDR_W = 19;
   localparam int STAT_W = 2;
   localparam int SIZE_W = 20;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 20;
   localparam int LIMIT_W    = 20;
   localparam int CHUNK_W    = 20;
   localparam int REPLIM_W   = 8;
   localparam int SPLIT_W    = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_LIMIT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_LIM = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPLIT_MIN  = 2'd3;

   localparam logic [LIMIT_W-1:0]  RST_HEAP_LIMIT = 20'd524288;
   localparam logic [CHUNK_W-1:0]  RST_CHUNK      = 20'd65536;
   localparam logic [REPLIM_W-1:0] RST_REPEAT_LIM = 8'd60;
   localparam logic [SPLIT_W-1:0]  RST_SPLIT_MIN  = 13'd128;

   // Request actions and response status codes
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OOM     = 2'd1;
   localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

   // Block layout
   localparam logic [WORD_W-1:0] SENTINEL     = 64'd2;
   localparam logic [SIZE_W-1:0] MIN_BLOCK    = 20'd32;
   localparam logic [WORD_W-1:0] PROLOGUE_TAG = 64'd17;
   localparam logic [WORD_W-1:0] INIT_FREE    = 64'd32;
   localparam logic [WORD_W-1:0] EPILOGUE_TAG = 64'd1;
   localparam logic [WORD_W-1:0] INIT_HEAD    = 64'd4;
   localparam logic [HEAP_AW:0]  INIT_TOP     = 17'd8;
   localparam logic [SIZE_W-1:0] INIT_LAST    = 20'd4;

endpackage

`default_nettype wire

// File: src/ffa_req_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if
// Request channel: allocate or free transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_req_if import ffa_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              action;
   logic [REQ_W-1:0]  request_bytes;
   logic [ADDR_W-1:0] block_address;

   modport source (output valid, output action, output request_bytes,
                   output block_address, input ready);
   modport sink   (input valid, input action, input request_bytes,
                   input block_address, output ready);
endinterface

`default_nettype wire

// File: src/ffa_rsp_if.sv
// ----------------------------------------------------------------------------
// ffa_rsp_if
// Response channel: granted address and status with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffa_rsp_if import ffa_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] granted_address;
   logic [STAT_W-1:0] status;

   modport source (output valid, output granted_address, output status, input ready);
   modport sink   (input valid, input granted_address, input status, output ready);
endinterface

`default_nettype wire

// File: src/first_fit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Boundary-tagged heap in one synchronous RAM, explicit free list, first-fit
// search, splitting and coalescing, run by a sequencer with subroutine states.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          content
//  req_chan  in   valid/ready        action, request_bytes, block_address
//  rsp_chan  out  valid/ready        granted_address, status
//  csr_*     in   write enable only  csr_index, csr_write_data
//
//  Every RAM read is registered and every tag or link write takes the port;
//  the single RAM port sets the pace. An allocate walks the free list from
//  its head for the first block that fits; a split and a free are each
//  followed by a coalesce, and heap growth writes new tags and coalesces.
//  After reset the RAM is swept once with req ready low.
//  A finished response waits in an output register; a new request is taken
//  meanwhile, and the sequencer holds only if a second response is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_free_list_allocator_core import ffa_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ffa_req_if.sink                    req_chan,
   ffa_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   localparam int ST_N = 37;

   typedef enum logic [ST_N-1:0] {
      S_CLR   = ST_N'(1) << 0,
      S_IDLE  = ST_N'(1) << 1,
      S_DEC   = ST_N'(1) << 2,
      S_FR0   = ST_N'(1) << 3,
      S_FR1   = ST_N'(1) << 4,
      S_WK1   = ST_N'(1) << 5,
      S_WK2   = ST_N'(1) << 6,
      S_WK3   = ST_N'(1) << 7,
      S_NOFIT = ST_N'(1) << 8,
      S_G1RET = ST_N'(1) << 9,
      S_G2RET = ST_N'(1) << 10,
      S_GR0   = ST_N'(1) << 11,
      S_GR1   = ST_N'(1) << 12,
      S_PL0   = ST_N'(1) << 13,
      S_PL1   = ST_N'(1) << 14,
      S_PL3   = ST_N'(1) << 15,
      S_MG0   = ST_N'(1) << 16,
      S_MG1   = ST_N'(1) << 17,
      S_MG2   = ST_N'(1) << 18,
      S_MG3   = ST_N'(1) << 19,
      S_MG4   = ST_N'(1) << 20,
      S_MG5   = ST_N'(1) << 21,
      S_MG6   = ST_N'(1) << 22,
      S_MG7   = ST_N'(1) << 23,
      S_MG8   = ST_N'(1) << 24,
      S_MG9A  = ST_N'(1) << 25,
      S_MG9B  = ST_N'(1) << 26,
      S_LI0   = ST_N'(1) << 27,
      S_LI1   = ST_N'(1) << 28,
      S_LI2   = ST_N'(1) << 29,
      S_LR0   = ST_N'(1) << 30,
      S_LR1   = ST_N'(1) << 31,
      S_LR2   = ST_N'(1) << 32,
      S_LR3   = ST_N'(1) << 33,
      S_ST0   = ST_N'(1) << 34,
      S_ST1   = ST_N'(1) << 35,
      S_FIN   = ST_N'(1) << 36
   } state_type;

   // Heap RAM
   logic [WORD_W-1:0] heap_mem [HEAP_WORDS];
   logic [WORD_W-1:0] mem_q_ff;
   logic              rok_ff;
   logic              mem_we;
   logic [WORD_W-1:0] mem_addr;
   logic [WORD_W-1:0] mem_wdata;
   logic              mem_hit;
   logic [WORD_W-1:0] rdata;
   logic [WORD_W-1:0] rd_bsize;

   // Sequencer
   state_type state_ff, state_in;
   state_type st_ret_ff, st_ret_in;
   state_type lr_ret_ff, lr_ret_in;
   state_type mg_ret_ff, mg_ret_in;
   state_type gr_ret_ff, gr_ret_in;
   logic [HEAP_AW-1:0] clr_ff, clr_in;

   // Working registers
   logic [WORD_W-1:0] b_ff, b_in;
   logic [WORD_W-1:0] s_ff, s_in;
   logic [WORD_W-1:0] nx_ff, nx_in;
   logic [WORD_W-1:0] pv_ff, pv_in;
   logic [WORD_W-1:0] pe_ff, pe_in;
   logic [WORD_W-1:0] hn_ff, hn_in;
   logic [WORD_W-1:0] hp_ff, hp_in;
   logic              na_ff, na_in;
   logic [WORD_W-1:0] prev_ff, prev_in;
   logic [WORD_W-1:0] next_ff, next_in;
   logic [WORD_W-1:0] lr_x_ff, lr_x_in;
   logic [WORD_W-1:0] st_b_ff, st_b_in;
   logic [WORD_W-1:0] st_s_ff, st_s_in;
   logic [WORD_W-1:0] st_e_ff, st_e_in;
   logic              st_a_ff, st_a_in;
   logic [SIZE_W-1:0] asize_ff, asize_in;
   logic [HEAP_AW:0]  n_ff, n_in;
   logic [SIZE_W-4:0] gw_ff, gw_in;
   logic              gok_ff, gok_in;
   logic [HEAP_AW-1:0] grant_ff, grant_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic              act_ff, act_in;
   logic [REQ_W-1:0]  reqb_ff, reqb_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;

   // Allocator state
   logic [WORD_W-1:0]   head_ff, head_in;
   logic [HEAP_AW:0]    top_ff, top_in;
   logic [SIZE_W-1:0]   last_ff, last_in;
   logic [7:0]          rep_ff, rep_in;

   // Configuration
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [REPLIM_W-1:0] replim_ff, replim_in;
   logic [SPLIT_W-1:0]  split_ff, split_in;

   // Response register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;

   // Combinational helpers
   logic [REQ_W:0]      sum_c;
   logic [REQ_W:0]      rnd_c;
   logic [SIZE_W-1:0]   asize_c;
   logic [SIZE_W-3:0]   ws_c;
   logic [SIZE_W:0]     gs_c;
   logic [SIZE_W+1:0]   need_c;
   logic [LIMIT_W-1:0]  lim_c;
   logic [SIZE_W-1:0]   e_c;
   logic [SPLIT_W-1:0]  thr_c;
   logic [WORD_W-1:0]   rem_c;
   logic [WORD_W-1:0]   asize64;
   logic                req_fire;
   logic                rsp_free;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.granted_address = rsp_addr_ff;
   assign rsp_chan.status          = rsp_stat_ff;

   // RAM port: one access per cycle, registered read
   assign mem_hit  = (mem_addr[WORD_W-1:HEAP_AW] == '0);
   assign rdata    = rok_ff ? mem_q_ff : '0;
   assign rd_bsize = {rdata[WORD_W-1:4], 4'b0000};

   always_ff @(posedge clock) begin
      if (mem_we && mem_hit) begin
         heap_mem[mem_addr[HEAP_AW-1:0]] <= mem_wdata;
      end
      mem_q_ff <= heap_mem[mem_addr[HEAP_AW-1:0]];
      rok_ff   <= mem_hit;
   end

   // Address and data for the RAM port per state
   always_comb begin
      mem_we    = 1'b0;
      mem_addr  = '0;
      mem_wdata = '0;
      case (state_ff)
         S_CLR: begin
            mem_we   = 1'b1;
            mem_addr = WORD_W'(clr_ff);
            case (clr_ff)
               HEAP_AW'(1), HEAP_AW'(2): mem_wdata = PROLOGUE_TAG;
               HEAP_AW'(3), HEAP_AW'(6): mem_wdata = INIT_FREE;
               HEAP_AW'(5):              mem_wdata = SENTINEL;
               HEAP_AW'(7):              mem_wdata = EPILOGUE_TAG;
               default:                  mem_wdata = '0;
            endcase
         end
         S_FR0, S_WK1, S_MG0, S_PL0: mem_addr = b_ff - 64'd1;
         S_WK2: mem_addr = b_ff + 64'd1;
         S_MG2: mem_addr = nx_ff - 64'd1;
         S_MG3: mem_addr = b_ff - 64'd2;
         S_MG5: mem_addr = pv_ff - 64'd1;
         S_MG7: mem_addr = pe_ff - 64'd2;
         S_LR0: mem_addr = lr_x_ff;
         S_LR1: mem_addr = lr_x_ff + 64'd1;
         S_LR2: begin
            mem_we    = (prev_ff != '0);
            mem_addr  = prev_ff + 64'd1;
            mem_wdata = rdata;
         end
         S_LR3: begin
            mem_we    = (next_ff != SENTINEL);
            mem_addr  = next_ff;
            mem_wdata = prev_ff;
         end
         S_ST0: begin
            mem_we    = 1'b1;
            mem_addr  = st_b_ff - 64'd1;
            mem_wdata = {st_s_ff[WORD_W-1:1], st_s_ff[0] | st_a_ff};
         end
         S_ST1: begin
            mem_we    = 1'b1;
            mem_addr  = st_e_ff - 64'd2;
            mem_wdata = {st_s_ff[WORD_W-1:1], st_s_ff[0] | st_a_ff};
         end
         S_GR1: begin
            mem_we    = 1'b1;
            mem_addr  = WORD_W'(top_ff - 1'b1);
            mem_wdata = EPILOGUE_TAG;
         end
         S_LI0: begin
            mem_we    = 1'b1;
            mem_addr  = b_ff + 64'd1;
            mem_wdata = head_ff;
         end
         S_LI1: begin
            mem_we    = (head_ff != SENTINEL);
            mem_addr  = head_ff;
            mem_wdata = b_ff;
         end
         S_LI2: begin
            mem_we    = 1'b1;
            mem_addr  = b_ff;
            mem_wdata = '0;
         end
         default: ;
      endcase
   end

   // Request rounding, growth bound and split threshold
   always_comb begin
      sum_c   = {1'b0, reqb_ff} + (REQ_W+1)'(31);
      rnd_c   = {sum_c[REQ_W:4], 4'b0000};
      asize_c = (reqb_ff <= REQ_W'(16)) ? MIN_BLOCK : rnd_c[SIZE_W-1:0];
      ws_c    = {1'b0, gw_ff} + (SIZE_W-2)'(gw_ff[0]);
      gs_c    = {ws_c, 3'b000};
      lim_c   = (limit_ff > LIMIT_W'(HEAP_BYTES)) ? LIMIT_W'(HEAP_BYTES) : limit_ff;
      need_c  = (SIZE_W+2)'({top_ff, 3'b000}) + (SIZE_W+2)'(gs_c);
      e_c     = (asize_ff > chunk_ff) ? asize_ff : chunk_ff;
      thr_c   = (split_ff < SPLIT_W'(MIN_BLOCK)) ? SPLIT_W'(MIN_BLOCK) : split_ff;
      asize64 = WORD_W'(asize_ff);
      rem_c   = rd_bsize - asize64;
   end

   // Sequencer next state
   always_comb begin
      state_in = state_ff;
      st_ret_in = st_ret_ff; lr_ret_in = lr_ret_ff;
      mg_ret_in = mg_ret_ff; gr_ret_in = gr_ret_ff;
      clr_in = clr_ff;
      b_in = b_ff; s_in = s_ff; nx_in = nx_ff; pv_in = pv_ff; pe_in = pe_ff;
      hn_in = hn_ff; hp_in = hp_ff; na_in = na_ff;
      prev_in = prev_ff; next_in = next_ff; lr_x_in = lr_x_ff;
      st_b_in = st_b_ff; st_s_in = st_s_ff; st_e_in = st_e_ff; st_a_in = st_a_ff;
      asize_in = asize_ff; n_in = n_ff; gw_in = gw_ff; gok_in = gok_ff;
      grant_in = grant_ff; stat_in = stat_ff;
      act_in = act_ff; reqb_in = reqb_ff; addr_in = addr_ff;
      head_in = head_ff; top_in = top_ff; last_in = last_ff; rep_in = rep_ff;
      limit_in = limit_ff; chunk_in = chunk_ff; replim_in = replim_ff; split_in = split_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in = rsp_addr_ff; rsp_stat_in = rsp_stat_ff;

      // Configuration writes
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_HEAP_LIMIT: limit_in  = csr_write_data[LIMIT_W-1:0];
            CSR_CHUNK:      chunk_in  = csr_write_data[CHUNK_W-1:0];
            CSR_REPEAT_LIM: replim_in = csr_write_data[REPLIM_W-1:0];
            CSR_SPLIT_MIN:  split_in  = csr_write_data[SPLIT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Sweep the heap RAM to its initial layout
         S_CLR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         // Take a transaction
         S_IDLE: begin
            if (req_fire) begin
               act_in   = req_chan.action;
               reqb_in  = req_chan.request_bytes;
               addr_in  = req_chan.block_address;
               state_in = S_DEC;
            end
         end
         // Decode the request, apply the repeat shortcut
         S_DEC: begin
            stat_in  = STAT_DONE;
            grant_in = '0;
            if (act_ff == ACT_FREE) begin
               if (addr_ff == '0) begin
                  stat_in  = STAT_IGNORED;
                  state_in = S_FIN;
               end else begin
                  b_in     = WORD_W'(addr_ff[ADDR_W-1:3]);
                  state_in = S_FR0;
               end
            end else if (reqb_ff == '0) begin
               stat_in  = STAT_IGNORED;
               state_in = S_FIN;
            end else if (reqb_ff > REQ_W'(16) && rnd_c[REQ_W]) begin
               stat_in  = STAT_OOM;
               state_in = S_FIN;
            end else begin
               asize_in = asize_c;
               b_in     = head_ff;
               n_in     = '0;
               state_in = S_WK1;
               if (last_ff == asize_c) begin
                  if (rep_ff > replim_ff) begin
                     gw_in     = asize_c[SIZE_W-1:3];
                     gr_ret_in = S_G1RET;
                     state_in  = S_GR0;
                  end else if (rep_ff != 8'hFF) begin
                     rep_in = rep_ff + 8'd1;
                  end
               end else begin
                  rep_in = '0;
               end
            end
         end
         // Free: clear the allocated bit, then coalesce
         S_FR0: state_in = S_FR1;
         S_FR1: begin
            st_b_in   = b_ff;
            st_s_in   = rd_bsize;
            st_a_in   = 1'b0;
            st_ret_in = S_MG0;
            mg_ret_in = S_FIN;
            state_in  = S_ST0;
         end
         // First-fit walk
         S_WK1: begin
            state_in = (n_ff == (HEAP_AW+1)'(HEAP_WORDS)) ? S_NOFIT : S_WK2;
         end
         S_WK2: begin
            if (rdata[0]) begin
               state_in = S_NOFIT;
            end else if (asize64 <= rd_bsize) begin
               last_in  = asize_ff;
               state_in = S_PL0;
            end else begin
               state_in = S_WK3;
            end
         end
         S_WK3: begin
            b_in     = rdata;
            n_in     = n_ff + 1'b1;
            state_in = S_WK1;
         end
         // No fit: grow by the larger of size and chunk
         S_NOFIT: begin
            gw_in     = e_c[SIZE_W-1:3];
            gr_ret_in = S_G2RET;
            state_in  = S_GR0;
         end
         S_G1RET: state_in = gok_ff ? S_PL0 : S_NOFIT;
         S_G2RET: begin
            if (gok_ff) begin
               state_in = S_PL0;
            end else begin
               stat_in  = STAT_OOM;
               state_in = S_FIN;
            end
         end
         // Heap growth
         S_GR0: begin
            if (need_c > (SIZE_W+2)'(lim_c)) begin
               gok_in   = 1'b0;
               state_in = gr_ret_ff;
            end else begin
               gok_in    = 1'b1;
               b_in      = WORD_W'(top_ff);
               top_in    = top_ff + ws_c[HEAP_AW:0];
               st_b_in   = WORD_W'(top_ff);
               st_s_in   = WORD_W'(gs_c);
               st_a_in   = 1'b0;
               st_ret_in = S_GR1;
               state_in  = S_ST0;
            end
         end
         S_GR1: begin
            mg_ret_in = gr_ret_ff;
            state_in  = S_MG0;
         end
         // Place: mark allocated, split off the remainder if large enough
         S_PL0: begin
            grant_in = b_ff[HEAP_AW-1:0];
            state_in = S_PL1;
         end
         S_PL1: begin
            s_in      = rd_bsize;
            st_b_in   = b_ff;
            st_a_in   = 1'b1;
            st_ret_in = S_LR0;
            lr_x_in   = b_ff;
            state_in  = S_ST0;
            if (rd_bsize >= asize64 && rem_c >= WORD_W'(thr_c)) begin
               st_s_in   = asize64;
               lr_ret_in = S_PL3;
            end else begin
               st_s_in   = rd_bsize;
               lr_ret_in = S_FIN;
            end
         end
         S_PL3: begin
            b_in      = b_ff + WORD_W'(asize_ff[SIZE_W-1:3]);
            st_b_in   = b_ff + WORD_W'(asize_ff[SIZE_W-1:3]);
            st_s_in   = s_ff - asize64;
            st_a_in   = 1'b0;
            st_ret_in = S_MG0;
            mg_ret_in = S_FIN;
            state_in  = S_ST0;
         end
         // Coalesce: gather both neighbours' tags
         S_MG0: state_in = S_MG1;
         S_MG1: begin
            s_in     = rd_bsize;
            nx_in    = b_ff + {3'b000, rd_bsize[WORD_W-1:3]};
            state_in = S_MG2;
         end
         S_MG2: state_in = S_MG3;
         S_MG3: begin
            na_in    = rdata[0];
            hn_in    = rd_bsize;
            state_in = S_MG4;
         end
         S_MG4: begin
            pv_in    = b_ff - {3'b000, rd_bsize[WORD_W-1:3]};
            state_in = S_MG5;
         end
         S_MG5: state_in = S_MG6;
         S_MG6: begin
            hp_in    = rd_bsize;
            pe_in    = pv_ff + {3'b000, rd_bsize[WORD_W-1:3]};
            state_in = S_MG7;
         end
         S_MG7: state_in = S_MG8;
         S_MG8: begin
            if (na_ff && (rdata[0] || pv_ff == b_ff)) begin
               state_in = S_LI0;
            end else if (na_ff) begin
               s_in      = s_ff + hp_ff;
               b_in      = pv_ff;
               lr_x_in   = pv_ff;
               lr_ret_in = S_MG9A;
               state_in  = S_LR0;
            end else if (rdata[0] || pv_ff == b_ff) begin
               s_in      = s_ff + hn_ff;
               lr_x_in   = nx_ff;
               lr_ret_in = S_MG9A;
               state_in  = S_LR0;
            end else begin
               s_in      = s_ff + hp_ff;
               lr_x_in   = pv_ff;
               lr_ret_in = S_MG9B;
               state_in  = S_LR0;
            end
         end
         S_MG9B: begin
            s_in      = s_ff + hn_ff;
            b_in      = pv_ff;
            lr_x_in   = nx_ff;
            lr_ret_in = S_MG9A;
            state_in  = S_LR0;
         end
         S_MG9A: begin
            st_b_in   = b_ff;
            st_s_in   = s_ff;
            st_a_in   = 1'b0;
            st_ret_in = S_LI0;
            state_in  = S_ST0;
         end
         // Insert at the list head
         S_LI0: state_in = S_LI1;
         S_LI1: state_in = S_LI2;
         S_LI2: begin
            head_in  = b_ff;
            state_in = mg_ret_ff;
         end
         // Unlink a block from the list
         S_LR0: state_in = S_LR1;
         S_LR1: begin
            prev_in  = rdata;
            state_in = S_LR2;
         end
         S_LR2: begin
            next_in = rdata;
            if (prev_ff == '0) begin
               head_in = rdata;
            end
            state_in = S_LR3;
         end
         S_LR3: state_in = lr_ret_ff;
         // Write header and footer tags
         S_ST0: begin
            st_e_in  = st_b_ff + {3'b000, st_s_ff[WORD_W-1:3]};
            state_in = S_ST1;
         end
         S_ST1: state_in = st_ret_ff;
         // Hand the result to the output register
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in  = ADDR_W'({grant_ff, 3'b000});
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         st_ret_ff    <= S_IDLE;
         lr_ret_ff    <= S_IDLE;
         mg_ret_ff    <= S_IDLE;
         gr_ret_ff    <= S_IDLE;
         head_ff      <= INIT_HEAD;
         top_ff       <= INIT_TOP;
         last_ff      <= INIT_LAST;
         rep_ff       <= '0;
         limit_ff     <= RST_HEAP_LIMIT;
         chunk_ff     <= RST_CHUNK;
         replim_ff    <= RST_REPEAT_LIM;
         split_ff     <= RST_SPLIT_MIN;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         st_ret_ff    <= st_ret_in;
         lr_ret_ff    <= lr_ret_in;
         mg_ret_ff    <= mg_ret_in;
         gr_ret_ff    <= gr_ret_in;
         head_ff      <= head_in;
         top_ff       <= top_in;
         last_ff      <= last_in;
         rep_ff       <= rep_in;
         limit_ff     <= limit_in;
         chunk_ff     <= chunk_in;
         replim_ff    <= replim_in;
         split_ff     <= split_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers
   always_ff @(posedge clock) begin
      b_ff <= b_in; s_ff <= s_in; nx_ff <= nx_in; pv_ff <= pv_in; pe_ff <= pe_in;
      hn_ff <= hn_in; hp_ff <= hp_in; na_ff <= na_in;
      prev_ff <= prev_in; next_ff <= next_in; lr_x_ff <= lr_x_in;
      st_b_ff <= st_b_in; st_s_ff <= st_s_in; st_e_ff <= st_e_in; st_a_ff <= st_a_in;
      asize_ff <= asize_in; n_ff <= n_in; gw_ff <= gw_in; gok_ff <= gok_in;
      grant_ff <= grant_in; stat_ff <= stat_in;
      act_ff <= act_in; reqb_ff <= reqb_in; addr_ff <= addr_in;
      rsp_addr_ff <= rsp_addr_in; rsp_stat_ff <= rsp_stat_in;
   end

endmodule

`default_nettype wire

// File: src/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks of the allocator core, bound into the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module ffa_checker import ffa_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [ADDR_W-1:0] rsp_granted_address,
   input wire logic [STAT_W-1:0] rsp_status
);

   // Hold a stalled response transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_granted_address)
                                   && $stable(rsp_status))
      else $error("response changed while stalled");

   // Status is one of the defined codes
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == STAT_DONE || rsp_status == STAT_OOM ||
                     rsp_status == STAT_IGNORED))
      else $error("undefined status code");

   // No address with a failed or ignored request
   a_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_DONE |-> rsp_granted_address == '0)
      else $error("address returned with a non-done status");

   // Granted addresses are word aligned
   a_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_granted_address[2:0] == 3'b000)
      else $error("granted address not word aligned");

   // Requests wait while the heap is being initialized
   a_init_block: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ready)
      else $error("request taken during heap initialization");

endmodule

bind first_fit_free_list_allocator_core ffa_checker u_ffa_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_chan.valid),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_granted_address (rsp_chan.granted_address),
   .rsp_status          (rsp_chan.status)
);

`default_nettype wire
